// ===== rtl/bracket_balance_checker_defines.svh =====
// assertion macros used by the port-level checker file
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BBC_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// next-cycle implication, checked outside reset
`define BBC_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

// ===== rtl/bbc_pkg.sv =====
// package with shared types and constants of the bracket balance checker
`timescale 1ns / 1ps
`default_nettype none
package bbc_pkg;

  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_MISMATCH = 3'd1,
    VERDICT_EMPTY    = 3'd2,
    VERDICT_UNCLOSED = 3'd3,
    VERDICT_OVERFLOW = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    KIND_PAREN   = 2'd0,
    KIND_BRACE   = 2'd1,
    KIND_BRACKET = 2'd2
  } kind_t;

  localparam logic [7:0] CH_PAREN_OPEN    = 8'h28;
  localparam logic [7:0] CH_PAREN_CLOSE   = 8'h29;
  localparam logic [7:0] CH_BRACE_OPEN    = 8'h7B;
  localparam logic [7:0] CH_BRACE_CLOSE   = 8'h7D;
  localparam logic [7:0] CH_BRACKET_OPEN  = 8'h5B;
  localparam logic [7:0] CH_BRACKET_CLOSE = 8'h5D;

  localparam int unsigned PEAK_W = 8;

  typedef struct packed {
    logic     is_last;
    logic     pop_ok;
    kind_t    kind;
    verdict_t early_err;
  } stage_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/bbc_if.sv =====
// channel interfaces for character input and verdict output
`timescale 1ns / 1ps
`default_nettype none
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;

  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink (input valid, input char_byte, input is_last, output ready);
endinterface

interface bbc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;
  logic [7:0] max_depth_seen;

  modport source (output valid, output verdict, output max_depth_seen, input ready);
  modport sink (input valid, input verdict, input max_depth_seen, output ready);
endinterface
`default_nettype wire

// ===== rtl/bbc_stack_ram.sv =====
// bracket stack memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module bbc_stack_ram #(
  parameter int unsigned STACK_DEPTH = 128,
  parameter int unsigned AW = 7
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire bbc_pkg::kind_t wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output bbc_pkg::kind_t     rd_data
);

  bbc_pkg::kind_t mem [STACK_DEPTH];
  bbc_pkg::kind_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/bbc_front.sv =====
// decode stage: classifies the byte, keeps the stack count, drives the stack memory
`timescale 1ns / 1ps
`default_nettype none
module bbc_front #(
  parameter int unsigned STACK_DEPTH = 128,
  parameter int unsigned AW = 7,
  parameter int unsigned CW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic [7:0]     char_byte,
  input  wire logic           is_last,
  output bbc_pkg::stage_ctl_t ctl,
  output logic [CW-1:0]       cnt_after,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output bbc_pkg::kind_t      wr_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr
);

  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  cnt_nxt;
  logic [CW-1:0]  cnt_m1;
  logic           opener;
  logic           closer;
  bbc_pkg::kind_t kind;
  logic           full;
  logic           empty;
  logic           push_ok;
  logic           pop_ok;

  always_comb begin
    opener = 1'b0;
    closer = 1'b0;
    kind   = bbc_pkg::KIND_PAREN;
    unique case (char_byte)
      bbc_pkg::CH_PAREN_OPEN: begin
        opener = 1'b1;
        kind   = bbc_pkg::KIND_PAREN;
      end
      bbc_pkg::CH_BRACE_OPEN: begin
        opener = 1'b1;
        kind   = bbc_pkg::KIND_BRACE;
      end
      bbc_pkg::CH_BRACKET_OPEN: begin
        opener = 1'b1;
        kind   = bbc_pkg::KIND_BRACKET;
      end
      bbc_pkg::CH_PAREN_CLOSE: begin
        closer = 1'b1;
        kind   = bbc_pkg::KIND_PAREN;
      end
      bbc_pkg::CH_BRACE_CLOSE: begin
        closer = 1'b1;
        kind   = bbc_pkg::KIND_BRACE;
      end
      bbc_pkg::CH_BRACKET_CLOSE: begin
        closer = 1'b1;
        kind   = bbc_pkg::KIND_BRACKET;
      end
      default: begin
        opener = 1'b0;
        closer = 1'b0;
      end
    endcase
  end

  assign full    = (cnt_r == CW'(STACK_DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = opener && !full;
  assign pop_ok  = closer && !empty;
  assign cnt_m1  = cnt_r - CW'(1);

  always_comb begin
    priority if (push_ok) begin
      cnt_after = cnt_r + CW'(1);
    end else if (pop_ok) begin
      cnt_after = cnt_m1;
    end else begin
      cnt_after = cnt_r;
    end
    cnt_nxt = is_last ? '0 : cnt_after;
  end

  always_comb begin
    ctl.is_last = is_last;
    ctl.pop_ok  = pop_ok;
    ctl.kind    = kind;
    priority if (opener && full) begin
      ctl.early_err = bbc_pkg::VERDICT_OVERFLOW;
    end else if (closer && empty) begin
      ctl.early_err = bbc_pkg::VERDICT_EMPTY;
    end else begin
      ctl.early_err = bbc_pkg::VERDICT_OK;
    end
  end

  assign wr_en   = in_fire && push_ok;
  assign wr_addr = cnt_r[AW-1:0];
  assign wr_data = kind;
  assign rd_en   = in_fire && pop_ok;
  assign rd_addr = cnt_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_fire) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bbc_back.sv =====
// check stage: match against popped entry, sticky error, depth peak, verdict register
`timescale 1ns / 1ps
`default_nettype none
module bbc_back #(
  parameter int unsigned CW = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_fire,
  input  wire bbc_pkg::stage_ctl_t ctl,
  input  wire logic [CW-1:0]       cnt_after,
  input  wire bbc_pkg::kind_t      top_kind,
  output logic                     s2_go,
  bbc_out_if.source                out_bus
);

  bbc_pkg::stage_ctl_t ctl_r;
  logic [CW-1:0]       cnt_r;
  logic                s2_v_r;
  bbc_pkg::verdict_t   err_r;
  bbc_pkg::verdict_t   err_nxt;
  bbc_pkg::verdict_t   item_err;
  bbc_pkg::verdict_t   verdict;
  logic [CW-1:0]       peak_r;
  logic [CW-1:0]       peak_nxt;
  logic [CW+7:0]       peak_ext;
  logic [bbc_pkg::PEAK_W-1:0] peak_sat;
  logic                out_v_r;
  bbc_pkg::verdict_t   out_verdict_r;
  logic [bbc_pkg::PEAK_W-1:0] out_depth_r;
  logic                s2_fire;

  assign s2_go   = !s2_v_r || !ctl_r.is_last || !out_v_r || out_bus.ready;
  assign s2_fire = s2_v_r && s2_go;

  always_comb begin
    priority if (ctl_r.early_err != bbc_pkg::VERDICT_OK) begin
      item_err = ctl_r.early_err;
    end else if (ctl_r.pop_ok && (top_kind != ctl_r.kind)) begin
      item_err = bbc_pkg::VERDICT_MISMATCH;
    end else begin
      item_err = bbc_pkg::VERDICT_OK;
    end

    err_nxt  = (err_r != bbc_pkg::VERDICT_OK) ? err_r : item_err;
    peak_nxt = peak_r;
    if ((err_nxt == bbc_pkg::VERDICT_OK) && (cnt_r > peak_r)) begin
      peak_nxt = cnt_r;
    end

    priority if (err_nxt != bbc_pkg::VERDICT_OK) begin
      verdict = err_nxt;
    end else if (cnt_r != '0) begin
      verdict = bbc_pkg::VERDICT_UNCLOSED;
    end else begin
      verdict = bbc_pkg::VERDICT_OK;
    end

    peak_ext = {8'd0, peak_nxt};
    peak_sat = (peak_ext > (CW + 8)'(255)) ? 8'hFF : peak_ext[bbc_pkg::PEAK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ctl_r <= ctl;
      cnt_r <= cnt_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      err_r  <= bbc_pkg::VERDICT_OK;
      peak_r <= '0;
    end else begin
      if (in_fire) begin
        s2_v_r <= 1'b1;
      end else if (s2_go) begin
        s2_v_r <= 1'b0;
      end
      if (s2_fire) begin
        if (ctl_r.is_last) begin
          err_r  <= bbc_pkg::VERDICT_OK;
          peak_r <= '0;
        end else begin
          err_r  <= err_nxt;
          peak_r <= peak_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_fire && ctl_r.is_last) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && ctl_r.is_last) begin
      out_verdict_r <= verdict;
      out_depth_r   <= peak_sat;
    end
  end

  assign out_bus.valid          = out_v_r;
  assign out_bus.verdict        = out_verdict_r;
  assign out_bus.max_depth_seen = out_depth_r;

endmodule
`default_nettype wire

// ===== rtl/bracket_balance_checker.sv =====
// top level: bracket balance check over a byte stream with a memory-held stack
// verdict path: check-stage register, then output register; the popped entry is
// compared in the check stage; throughput: one byte per cycle unless the verdict
// output stalls; the stack memory sees at most one push write or pop read per byte
// reset: clears stack count, sticky error, depth peak and all valid flags;
// stack memory contents are not cleared and need no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module bracket_balance_checker #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bbc_in_if.sink    in_bus,
  bbc_out_if.source out_bus
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  bbc_pkg::stage_ctl_t ctl;
  logic [CW-1:0]       cnt_after;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  bbc_pkg::kind_t      wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  bbc_pkg::kind_t      rd_data;
  logic                s2_go;
  logic                in_fire;

  assign in_bus.ready = s2_go;
  assign in_fire      = in_bus.valid && s2_go;

  bbc_front #(
    .STACK_DEPTH(STACK_DEPTH),
    .AW(AW),
    .CW(CW)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_fire(in_fire),
    .char_byte(in_bus.char_byte),
    .is_last(in_bus.is_last),
    .ctl(ctl),
    .cnt_after(cnt_after),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr)
  );

  bbc_stack_ram #(
    .STACK_DEPTH(STACK_DEPTH),
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  bbc_back #(
    .CW(CW)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .in_fire(in_fire),
    .ctl(ctl),
    .cnt_after(cnt_after),
    .top_kind(rd_data),
    .s2_go(s2_go),
    .out_bus(out_bus)
  );

endmodule
`default_nettype wire

// ===== rtl/bbc_checker.sv =====
// port-level checker for the bracket balance checker and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "bracket_balance_checker_defines.svh"
module bbc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_verdict,
  input wire logic [7:0] out_max_depth_seen
);

  // a pending verdict transaction stays offered
  `BBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "verdict dropped while stalled")
  // verdict codes stop at overflow
  `BBC_ASSERT_NOW(a_verdict_range, out_valid, out_verdict <= 3'(bbc_pkg::VERDICT_OVERFLOW), "verdict code out of range")
  // an unclosed or overflowing string must have pushed something
  `BBC_ASSERT_NOW(a_depth_open, out_valid && (out_verdict == 3'(bbc_pkg::VERDICT_UNCLOSED) || out_verdict == 3'(bbc_pkg::VERDICT_OVERFLOW)), out_max_depth_seen != 8'd0, "open verdict with zero depth")
  // a mismatch needs a popped opener
  `BBC_ASSERT_NOW(a_depth_mismatch, out_valid && out_verdict == 3'(bbc_pkg::VERDICT_MISMATCH), out_max_depth_seen != 8'd0, "mismatch with zero depth")

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_bus.valid),
  .out_ready(out_bus.ready),
  .out_verdict(out_bus.verdict),
  .out_max_depth_seen(out_bus.max_depth_seen)
);
`default_nettype wire
